[sv/lspa_pkg.sv]
`default_nettype none
package lspa_pkg;

	// field widths
	localparam int KIND_W  = 2;
	localparam int COORD_W = 32;
	localparam int REG_W   = 31;
	localparam int ANG_W   = 31;
	localparam int EXT_W   = 32;
	localparam int IDX_W   = 2;

	// internal datapath widths
	localparam int CANG_W = 34;
	localparam int VEC_W  = 36;
	localparam int CX_W   = 44;
	localparam int TRIG_W = 32;
	localparam int PROD_W = 72;
	localparam int QUO_W  = 31;
	localparam int DEN_W  = 32;

	localparam int CORDIC_STEPS_DEF = 24;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXTEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEED   = 2'd2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [IDX_W-1:0] REG_ANGLE  = 2'd1;
	localparam logic [IDX_W-1:0] REG_TOL    = 2'd2;

	// register reset values
	localparam logic [REG_W-1:0] RADIUS_RST = 31'd65536;
	localparam logic [REG_W-1:0] ANGLE_RST  = 31'd0;
	localparam logic [REG_W-1:0] TOL_RST    = 31'd6554;

	// angle constants, Q3.28; CORDIC_K has 30 fraction bits
	localparam logic signed [CANG_W-1:0] ANG_PI     = 34'sd843314857;
	localparam logic signed [CANG_W-1:0] ANG_2PI    = 34'sd1686629713;
	localparam logic signed [CANG_W-1:0] ANG_HPI    = 34'sd421657428;
	localparam logic signed [CX_W-1:0]   CORDIC_K   = 44'sd652032874;
	localparam logic [QUO_W-1:0]         Z_MAX      = 31'h7FFF_FFFF;

	typedef enum logic {CM_ROT, CM_VEC} cmode_t;

	typedef struct packed {
		logic                     start;
		cmode_t                   mode;
		logic signed [CANG_W-1:0] ang;
		logic signed [VEC_W-1:0]  vx;
		logic signed [VEC_W-1:0]  vy;
	} cordic_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [TRIG_W-1:0] cosv;
		logic signed [TRIG_W-1:0] sinv;
		logic signed [TRIG_W-1:0] angv;
	} cordic_rsp_t;

	typedef struct packed {
		logic                    start;
		logic signed [VEC_W-1:0] a;
		logic signed [VEC_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [PROD_W-1:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic             start;
		logic [DEN_W-1:0] den;
		logic [REG_W-1:0] rad;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quot;
	} div_rsp_t;

	// arctangent of 2^-i, Q3.28
	function automatic logic [27:0] atan_lut(input logic [4:0] i);
		logic [27:0] v;
		unique case (i)
			5'd0:  v = 28'd210828714;
			5'd1:  v = 28'd124459457;
			5'd2:  v = 28'd65760959;
			5'd3:  v = 28'd33381290;
			5'd4:  v = 28'd16755422;
			5'd5:  v = 28'd8385879;
			5'd6:  v = 28'd4193963;
			5'd7:  v = 28'd2097109;
			5'd8:  v = 28'd1048571;
			5'd9:  v = 28'd524287;
			5'd10: v = 28'd262144;
			5'd11: v = 28'd131072;
			5'd12: v = 28'd65536;
			5'd13: v = 28'd32768;
			5'd14: v = 28'd16384;
			5'd15: v = 28'd8192;
			5'd16: v = 28'd4096;
			5'd17: v = 28'd2048;
			5'd18: v = 28'd1024;
			5'd19: v = 28'd512;
			5'd20: v = 28'd256;
			5'd21: v = 28'd128;
			5'd22: v = 28'd64;
			5'd23: v = 28'd32;
			5'd24: v = 28'd16;
			5'd25: v = 28'd8;
			5'd26: v = 28'd4;
			5'd27: v = 28'd2;
			5'd28: v = 28'd1;
			default: v = 28'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

[sv/lspa_if.sv]
`default_nettype none
interface lspa_point_if;
	logic                                 valid;
	logic                                 ready;
	logic [lspa_pkg::KIND_W-1:0]          kind;
	logic signed [lspa_pkg::COORD_W-1:0]  point_x;
	logic signed [lspa_pkg::COORD_W-1:0]  point_y;
	modport source(output valid, kind, point_x, point_y, input ready);
	modport sink(input valid, kind, point_x, point_y, output ready);
endinterface

interface lspa_result_if;
	logic                               valid;
	logic                               ready;
	logic                               associated;
	logic signed [lspa_pkg::ANG_W-1:0]  projected_angle;
	logic signed [lspa_pkg::EXT_W-1:0]  extent_low;
	logic signed [lspa_pkg::EXT_W-1:0]  extent_high;
	modport source(output valid, associated, projected_angle, extent_low, extent_high,
		input ready);
	modport sink(input valid, associated, projected_angle, extent_low, extent_high,
		output ready);
endinterface

interface lspa_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [lspa_pkg::IDX_W-1:0]  index;
	logic [lspa_pkg::REG_W-1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/lspa_mul.sv]
`default_nettype none
module lspa_mul (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lspa_pkg::mul_req_t req,
	output lspa_pkg::mul_rsp_t      rsp
);
	localparam int VW = lspa_pkg::VEC_W;
	localparam int PW = lspa_pkg::PROD_W;
	localparam int HW = VW / 2;

	typedef enum logic [1:0] {M_IDLE, M_LO, M_HI} mst_t;

	mst_t                 state_q;
	logic signed [VW-1:0] a_q;
	logic signed [VW-1:0] b_q;
	logic signed [PW-1:0] acc_q;
	logic                 done_q;

	logic signed [VW+HW:0]   pp_lo;
	logic signed [VW+HW-1:0] pp_hi;

	// low half unsigned, high half signed
	assign pp_lo = a_q * $signed({1'b0, b_q[HW-1:0]});
	assign pp_hi = a_q * $signed(b_q[VW-1:HW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			acc_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						a_q     <= req.a;
						b_q     <= req.b;
						state_q <= M_LO;
					end
				end
				M_LO: begin
					acc_q   <= PW'(pp_lo);
					state_q <= M_HI;
				end
				M_HI: begin
					acc_q   <= acc_q + (PW'(pp_hi) <<< HW);
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = acc_q;
endmodule
`default_nettype wire

[sv/lspa_div.sv]
`default_nettype none
module lspa_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lspa_pkg::div_req_t req,
	output lspa_pkg::div_rsp_t      rsp
);
	localparam int QW = lspa_pkg::QUO_W;
	localparam int DW = lspa_pkg::DEN_W;
	localparam int CW = $clog2(QW);

	typedef enum logic [1:0] {D_IDLE, D_STEP, D_DONE} dst_t;

	dst_t             state_q;
	logic [DW-1:0]    den_q;
	logic [DW-1:0]    rem_q;
	logic [QW-1:0]    num_q;
	logic [QW-1:0]    quo_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;

	logic [DW:0]      rsh;
	logic             ge;
	logic [DW:0]      rdiff;

	// restoring step, numerator is radius shifted up by 30
	assign rsh   = {rem_q, num_q[QW-1]};
	assign ge    = rsh >= {1'b0, den_q};
	assign rdiff = rsh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			den_q   <= '0;
			rem_q   <= '0;
			num_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						den_q <= req.den;
						rem_q <= DW'(req.rad >> 1);
						num_q <= {req.rad[0], {(QW-1){1'b0}}};
						cnt_q <= '0;
						// quotient would reach 2^31: saturate
						if (DW'(req.rad >> 1) >= req.den) begin
							quo_q   <= lspa_pkg::Z_MAX;
							state_q <= D_DONE;
						end else begin
							quo_q   <= '0;
							state_q <= D_STEP;
						end
					end
				end
				D_STEP: begin
					rem_q <= ge ? rdiff[DW-1:0] : rsh[DW-1:0];
					quo_q <= {quo_q[QW-2:0], ge};
					num_q <= num_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(QW-1)) state_q <= D_DONE;
				end
				D_DONE: begin
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
endmodule
`default_nettype wire

[sv/lspa_cordic.sv]
`default_nettype none
module lspa_cordic #(
	parameter int STEPS = lspa_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lspa_pkg::cordic_req_t req,
	output lspa_pkg::cordic_rsp_t      rsp
);
	localparam int IW = $clog2(STEPS);
	localparam int XW = lspa_pkg::CX_W;
	localparam int ZW = lspa_pkg::CANG_W;
	localparam int TW = lspa_pkg::TRIG_W;
	localparam int VW = lspa_pkg::VEC_W;

	typedef enum logic [2:0] {C_IDLE, C_RED, C_FOLD, C_NORM, C_SIGN, C_ITER, C_POST} cst_t;

	cst_t                 state_q;
	lspa_pkg::cmode_t     mode_q;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic signed [ZW-1:0] z_q;
	logic [IW-1:0]        i_q;
	logic                 neg_q;
	logic                 done_q;
	logic signed [TW-1:0] cos_q;
	logic signed [TW-1:0] sin_q;
	logic signed [TW-1:0] ang_q;

	logic                 pd;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [ZW-1:0] at;
	logic signed [ZW-1:0] a1;
	logic signed [ZW-1:0] a2;
	logic                 fneg;
	logic [XW-1:0]        xm;
	logic [XW-1:0]        ym;
	logic signed [ZW-1:0] zc;

	always_comb begin
		// rotation steers by residual angle, vectoring by sign of y
		pd = (mode_q == lspa_pkg::CM_ROT) ? !z_q[ZW-1] : y_q[XW-1];
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = $signed({6'b0, lspa_pkg::atan_lut(5'(i_q))});

		// wrap into [-pi, pi], then fold into [-pi/2, pi/2]
		if (z_q > lspa_pkg::ANG_PI) a1 = z_q - lspa_pkg::ANG_2PI;
		else if (z_q < -lspa_pkg::ANG_PI) a1 = z_q + lspa_pkg::ANG_2PI;
		else a1 = z_q;
		fneg = 1'b0;
		a2   = a1;
		if (a1 > lspa_pkg::ANG_HPI) begin
			a2   = a1 - lspa_pkg::ANG_PI;
			fneg = 1'b1;
		end else if (a1 < -lspa_pkg::ANG_HPI) begin
			a2   = a1 + lspa_pkg::ANG_PI;
			fneg = 1'b1;
		end

		xm = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
		ym = y_q[XW-1] ? XW'(-y_q) : XW'(y_q);

		if (z_q > lspa_pkg::ANG_PI) zc = lspa_pkg::ANG_PI;
		else if (z_q < -lspa_pkg::ANG_PI) zc = -lspa_pkg::ANG_PI;
		else zc = z_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			mode_q  <= lspa_pkg::CM_ROT;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			i_q     <= '0;
			neg_q   <= 1'b0;
			done_q  <= 1'b0;
			cos_q   <= '0;
			sin_q   <= '0;
			ang_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (req.start) begin
						mode_q <= req.mode;
						neg_q  <= 1'b0;
						i_q    <= '0;
						if (req.mode == lspa_pkg::CM_ROT) begin
							x_q     <= lspa_pkg::CORDIC_K;
							y_q     <= '0;
							z_q     <= req.ang;
							state_q <= C_RED;
						end else begin
							x_q <= {{(XW-VW){req.vx[VW-1]}}, req.vx};
							y_q <= {{(XW-VW){req.vy[VW-1]}}, req.vy};
							z_q <= '0;
							// zero vector gives angle zero
							if (req.vx == '0 && req.vy == '0) state_q <= C_POST;
							else state_q <= C_NORM;
						end
					end
				end
				C_RED: begin
					// remainder toward zero
					if (z_q >= lspa_pkg::ANG_2PI) z_q <= z_q - lspa_pkg::ANG_2PI;
					else if (z_q <= -lspa_pkg::ANG_2PI) z_q <= z_q + lspa_pkg::ANG_2PI;
					else state_q <= C_FOLD;
				end
				C_FOLD: begin
					z_q     <= a2;
					neg_q   <= fneg;
					state_q <= C_ITER;
				end
				C_NORM: begin
					// shift up by 8 while both magnitudes are below 2^32, then double until one reaches 2^40
					if (xm[XW-1:32] == '0 && ym[XW-1:32] == '0) begin
						x_q <= x_q <<< 8;
						y_q <= y_q <<< 8;
					end else if (xm[XW-1:40] == '0 && ym[XW-1:40] == '0) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end else begin
						state_q <= C_SIGN;
					end
				end
				C_SIGN: begin
					if (x_q[XW-1]) begin
						z_q <= y_q[XW-1] ? -lspa_pkg::ANG_PI : lspa_pkg::ANG_PI;
						x_q <= -x_q;
						y_q <= -y_q;
					end
					state_q <= C_ITER;
				end
				C_ITER: begin
					x_q <= pd ? x_q - ys : x_q + ys;
					y_q <= pd ? y_q + xs : y_q - xs;
					z_q <= pd ? z_q - at : z_q + at;
					i_q <= i_q + 1'b1;
					if (i_q == IW'(STEPS-1)) state_q <= C_POST;
				end
				C_POST: begin
					cos_q   <= neg_q ? TW'(-x_q) : TW'(x_q);
					sin_q   <= neg_q ? TW'(-y_q) : TW'(y_q);
					ang_q   <= TW'(zc);
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.cosv = cos_q;
	assign rsp.sinv = sin_q;
	assign rsp.angv = ang_q;
endmodule
`default_nettype wire

[sv/line_segment_point_association_top.sv]
// point to line segment association, polar line form
//
// point: one beat per point (kind, point_x, point_y, Q16.16). kind 0 asks
//   whether the point belongs to the segment, kind 1 widens the extent,
//   kind 2 seeds both extent ends, kind 3 acts as a query.
// result: one beat per point with associated, projected_angle and the
//   extent angles after that point (Q3.28).
// cfg: register writes (line_radius, line_angle, endpoint_tolerance), always
//   ready; write only while no point is in flight.
// one point is in work at a time and point.ready is low meanwhile. one
//   shared cordic serves every sine/cosine and atan2 pass and one shared
//   multiplier every two-part multiply. kinds 1 and 2 and queries inside
//   the extent finish after the atan2 pass; a query that tests both
//   endpoints adds per endpoint two cordic passes, a 31-step radix-2
//   divide unless the cosine is zero, and up to five multiplies.
// reset clears the extents to zero and loads the register defaults.
// the result sits in an output register; while result.ready is low the next
//   point is still taken and held in its final step until the register frees.
`default_nettype none
module line_segment_point_association_top #(
	parameter int CORDIC_STEPS = lspa_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	lspa_point_if.sink     point,
	lspa_result_if.source  result,
	lspa_cfg_if.sink       cfg
);
	localparam int CW = lspa_pkg::COORD_W;
	localparam int RW = lspa_pkg::REG_W;
	localparam int VW = lspa_pkg::VEC_W;
	localparam int PW = lspa_pkg::PROD_W;
	localparam int TW = lspa_pkg::TRIG_W;
	localparam int ZW = lspa_pkg::CANG_W;
	localparam int QW = lspa_pkg::QUO_W;
	localparam int EW = lspa_pkg::EXT_W;
	localparam int AW = lspa_pkg::ANG_W;

	typedef enum logic [4:0] {
		S_IDLE, S_SC_LINE, S_MUL_XC, S_MUL_YS, S_MUL_DC, S_MUL_DS, S_ATAN,
		S_EP_ROT, S_EP_DIV, S_EP_SC, S_MUL_QC, S_MUL_QS, S_NEAR,
		S_SQ_DX, S_SQ_DY, S_SQ_TOL, S_DONE
	} sst_t;

	sst_t state_q;
	logic pend_q;

	// configuration
	logic [RW-1:0] radius_q;
	logic [RW-1:0] angle_q;
	logic [RW-1:0] tol_q;

	// segment extent
	logic signed [EW-1:0] ext1_q;
	logic signed [EW-1:0] ext2_q;

	// item datapath
	logic [lspa_pkg::KIND_W-1:0] kind_q;
	logic signed [CW-1:0]   x_q;
	logic signed [CW-1:0]   y_q;
	logic signed [TW-1:0]   c_q;
	logic signed [TW-1:0]   s_q;
	logic signed [PW-1:0]   acc_q;
	logic signed [VW-1:0]   d_q;
	logic signed [VW-1:0]   xp_q;
	logic signed [VW-1:0]   yp_q;
	logic signed [TW-1:0]   ang_q;
	logic                   assoc_q;
	logic                   ep_sel_q;
	logic                   cdneg_q;
	logic [lspa_pkg::DEN_W-1:0] cdmag_q;
	logic signed [QW+1:0]   q_q;
	logic signed [VW-1:0]   ex_q;
	logic signed [VW-1:0]   ey_q;
	logic [RW-1:0]          dx_q;
	logic [RW-1:0]          dy_q;

	// output register
	logic                   res_valid_q;
	logic                   res_assoc_q;
	logic signed [AW-1:0]   res_ang_q;
	logic signed [EW-1:0]   res_lo_q;
	logic signed [EW-1:0]   res_hi_q;

	lspa_pkg::cordic_req_t cr;
	lspa_pkg::cordic_rsp_t crsp;
	lspa_pkg::mul_req_t    mr;
	lspa_pkg::mul_rsp_t    mrsp;
	lspa_pkg::div_req_t    dr;
	lspa_pkg::div_rsp_t    drsp;

	lspa_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .req(cr), .rsp(crsp));
	lspa_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mr), .rsp(mrsp));
	lspa_div u_div (.clk(clk), .arst_n(arst_n), .req(dr), .rsp(drsp));

	logic signed [EW-1:0] t_sel;
	logic signed [EW-1:0] lo_cur;
	logic signed [EW-1:0] hi_cur;
	logic signed [EW-1:0] e1_ext;
	logic signed [EW-1:0] hi_ext;
	logic signed [PW-1:0] dsum;
	logic signed [VW:0]   ddx;
	logic signed [VW:0]   ddy;
	logic [VW:0]          dxa;
	logic [VW:0]          dya;
	logic                 far;
	logic signed [TW-1:0] cd;
	logic                 is_query;
	logic                 res_load;

	always_comb begin
		t_sel  = ep_sel_q ? ext2_q : ext1_q;
		lo_cur = (ext1_q < ext2_q) ? ext1_q : ext2_q;
		hi_cur = (ext1_q > ext2_q) ? ext1_q : ext2_q;
		// extend: low end first, then high end against the updated pair
		e1_ext = (crsp.angv < lo_cur) ? crsp.angv : ext1_q;
		hi_ext = (e1_ext > ext2_q) ? e1_ext : ext2_q;
		// signed distance of the point from the line, Q16.16 floored
		dsum = acc_q + mrsp.p - $signed({{(PW-RW-30){1'b0}}, radius_q, 30'b0});
		ddx  = {xp_q[VW-1], xp_q} - {ex_q[VW-1], ex_q};
		ddy  = {yp_q[VW-1], yp_q} - {ey_q[VW-1], ey_q};
		dxa  = ddx[VW] ? (VW+1)'(-ddx) : (VW+1)'(ddx);
		dya  = ddy[VW] ? (VW+1)'(-ddy) : (VW+1)'(ddy);
		far  = (dxa > (VW+1)'(tol_q)) || (dya > (VW+1)'(tol_q));
		cd   = crsp.cosv;
		is_query = (kind_q != lspa_pkg::KIND_EXTEND) && (kind_q != lspa_pkg::KIND_SEED);
		// finished beat moves into the output register once it is free
		res_load = (state_q == S_DONE) && (!res_valid_q || result.ready);
	end

	// operand steering into the shared units
	always_comb begin
		cr = '0;
		mr = '0;
		dr = '0;
		unique case (state_q)
			S_SC_LINE: begin
				cr.start = !pend_q;
				cr.mode  = lspa_pkg::CM_ROT;
				cr.ang   = {{(ZW-RW){1'b0}}, angle_q};
			end
			S_ATAN: begin
				cr.start = !pend_q;
				cr.mode  = lspa_pkg::CM_VEC;
				cr.vx    = xp_q;
				cr.vy    = yp_q;
			end
			S_EP_ROT: begin
				cr.start = !pend_q;
				cr.mode  = lspa_pkg::CM_ROT;
				cr.ang   = {{(ZW-EW){t_sel[EW-1]}}, t_sel} - {{(ZW-RW){1'b0}}, angle_q};
			end
			S_EP_SC: begin
				cr.start = !pend_q;
				cr.mode  = lspa_pkg::CM_ROT;
				cr.ang   = {{(ZW-EW){t_sel[EW-1]}}, t_sel};
			end
			S_EP_DIV: begin
				dr.start = !pend_q;
				dr.den   = cdmag_q;
				dr.rad   = radius_q;
			end
			S_MUL_XC: begin
				mr.start = !pend_q;
				mr.a     = {{(VW-CW){x_q[CW-1]}}, x_q};
				mr.b     = {{(VW-TW){c_q[TW-1]}}, c_q};
			end
			S_MUL_YS: begin
				mr.start = !pend_q;
				mr.a     = {{(VW-CW){y_q[CW-1]}}, y_q};
				mr.b     = {{(VW-TW){s_q[TW-1]}}, s_q};
			end
			S_MUL_DC: begin
				mr.start = !pend_q;
				mr.a     = d_q;
				mr.b     = {{(VW-TW){c_q[TW-1]}}, c_q};
			end
			S_MUL_DS: begin
				mr.start = !pend_q;
				mr.a     = d_q;
				mr.b     = {{(VW-TW){s_q[TW-1]}}, s_q};
			end
			S_MUL_QC: begin
				mr.start = !pend_q;
				mr.a     = {{(VW-QW-2){q_q[QW+1]}}, q_q};
				mr.b     = {{(VW-TW){c_q[TW-1]}}, c_q};
			end
			S_MUL_QS: begin
				mr.start = !pend_q;
				mr.a     = {{(VW-QW-2){q_q[QW+1]}}, q_q};
				mr.b     = {{(VW-TW){s_q[TW-1]}}, s_q};
			end
			S_SQ_DX: begin
				mr.start = !pend_q;
				mr.a     = {{(VW-RW){1'b0}}, dx_q};
				mr.b     = {{(VW-RW){1'b0}}, dx_q};
			end
			S_SQ_DY: begin
				mr.start = !pend_q;
				mr.a     = {{(VW-RW){1'b0}}, dy_q};
				mr.b     = {{(VW-RW){1'b0}}, dy_q};
			end
			S_SQ_TOL: begin
				mr.start = !pend_q;
				mr.a     = {{(VW-RW){1'b0}}, tol_q};
				mr.b     = {{(VW-RW){1'b0}}, tol_q};
			end
			default: ;
		endcase
	end

	assign point.ready = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			radius_q    <= lspa_pkg::RADIUS_RST;
			angle_q     <= lspa_pkg::ANGLE_RST;
			tol_q       <= lspa_pkg::TOL_RST;
			ext1_q      <= '0;
			ext2_q      <= '0;
			kind_q      <= '0;
			x_q         <= '0;
			y_q         <= '0;
			c_q         <= '0;
			s_q         <= '0;
			acc_q       <= '0;
			d_q         <= '0;
			xp_q        <= '0;
			yp_q        <= '0;
			ang_q       <= '0;
			assoc_q     <= 1'b0;
			ep_sel_q    <= 1'b0;
			cdneg_q     <= 1'b0;
			cdmag_q     <= '0;
			q_q         <= '0;
			ex_q        <= '0;
			ey_q        <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			res_valid_q <= 1'b0;
			res_assoc_q <= 1'b0;
			res_ang_q   <= '0;
			res_lo_q    <= '0;
			res_hi_q    <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					lspa_pkg::REG_RADIUS: radius_q <= cfg.data;
					lspa_pkg::REG_ANGLE:  angle_q  <= cfg.data;
					lspa_pkg::REG_TOL:    tol_q    <= cfg.data;
					default: ;
				endcase
			end

			if (res_load) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (point.valid) begin
						kind_q  <= point.kind;
						x_q     <= point.point_x;
						y_q     <= point.point_y;
						pend_q  <= 1'b0;
						state_q <= S_SC_LINE;
					end
				end
				S_SC_LINE: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (crsp.done) begin
						pend_q  <= 1'b0;
						c_q     <= crsp.cosv;
						s_q     <= crsp.sinv;
						state_q <= S_MUL_XC;
					end
				end
				S_MUL_XC: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (mrsp.done) begin
						pend_q  <= 1'b0;
						acc_q   <= mrsp.p;
						state_q <= S_MUL_YS;
					end
				end
				S_MUL_YS: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (mrsp.done) begin
						pend_q  <= 1'b0;
						d_q     <= dsum[VW+29:30];
						state_q <= S_MUL_DC;
					end
				end
				S_MUL_DC: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (mrsp.done) begin
						pend_q  <= 1'b0;
						xp_q    <= {{(VW-CW){x_q[CW-1]}}, x_q} - mrsp.p[VW+29:30];
						state_q <= S_MUL_DS;
					end
				end
				S_MUL_DS: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (mrsp.done) begin
						pend_q  <= 1'b0;
						yp_q    <= {{(VW-CW){y_q[CW-1]}}, y_q} - mrsp.p[VW+29:30];
						state_q <= S_ATAN;
					end
				end
				S_ATAN: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (crsp.done) begin
						pend_q   <= 1'b0;
						ang_q    <= crsp.angv;
						assoc_q  <= 1'b0;
						ep_sel_q <= 1'b0;
						if (kind_q == lspa_pkg::KIND_EXTEND) begin
							ext1_q  <= e1_ext;
							if (crsp.angv > hi_ext) ext2_q <= crsp.angv;
							state_q <= S_DONE;
						end else if (kind_q == lspa_pkg::KIND_SEED) begin
							ext1_q  <= crsp.angv;
							ext2_q  <= crsp.angv;
							state_q <= S_DONE;
						end else if (crsp.angv >= lo_cur && crsp.angv <= hi_cur) begin
							assoc_q <= 1'b1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_EP_ROT;
						end
					end
				end
				S_EP_ROT: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (crsp.done) begin
						pend_q  <= 1'b0;
						cdneg_q <= cd[TW-1];
						cdmag_q <= cd[TW-1] ? TW'(-cd) : TW'(cd);
						// cosine of zero: endpoint at the positive limit
						if (cd == '0) begin
							q_q     <= {2'b00, lspa_pkg::Z_MAX};
							state_q <= S_EP_SC;
						end else begin
							state_q <= S_EP_DIV;
						end
					end
				end
				S_EP_DIV: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (drsp.done) begin
						pend_q  <= 1'b0;
						q_q     <= cdneg_q ? -$signed({2'b00, drsp.quot})
						                   : $signed({2'b00, drsp.quot});
						state_q <= S_EP_SC;
					end
				end
				S_EP_SC: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (crsp.done) begin
						pend_q  <= 1'b0;
						c_q     <= crsp.cosv;
						s_q     <= crsp.sinv;
						state_q <= S_MUL_QC;
					end
				end
				S_MUL_QC: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (mrsp.done) begin
						pend_q  <= 1'b0;
						ex_q    <= mrsp.p[VW+29:30];
						state_q <= S_MUL_QS;
					end
				end
				S_MUL_QS: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (mrsp.done) begin
						pend_q  <= 1'b0;
						ey_q    <= mrsp.p[VW+29:30];
						state_q <= S_NEAR;
					end
				end
				S_NEAR: begin
					// box test first, squares only when inside it
					if (far) begin
						if (!ep_sel_q) begin
							ep_sel_q <= 1'b1;
							state_q  <= S_EP_ROT;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						dx_q    <= dxa[RW-1:0];
						dy_q    <= dya[RW-1:0];
						state_q <= S_SQ_DX;
					end
				end
				S_SQ_DX: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (mrsp.done) begin
						pend_q  <= 1'b0;
						acc_q   <= mrsp.p;
						state_q <= S_SQ_DY;
					end
				end
				S_SQ_DY: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (mrsp.done) begin
						pend_q  <= 1'b0;
						acc_q   <= acc_q + mrsp.p;
						state_q <= S_SQ_TOL;
					end
				end
				S_SQ_TOL: begin
					if (!pend_q) pend_q <= 1'b1;
					else if (mrsp.done) begin
						pend_q <= 1'b0;
						if (acc_q <= mrsp.p) begin
							assoc_q <= 1'b1;
							state_q <= S_DONE;
						end else if (!ep_sel_q) begin
							ep_sel_q <= 1'b1;
							state_q  <= S_EP_ROT;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					// wait for the output register to free
					if (res_load) begin
						res_assoc_q <= assoc_q;
						res_ang_q   <= ang_q[AW-1:0];
						res_lo_q    <= ext1_q;
						res_hi_q    <= ext2_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid           = res_valid_q;
	assign result.associated      = res_assoc_q;
	assign result.projected_angle = res_ang_q;
	assign result.extent_low      = res_lo_q;
	assign result.extent_high     = res_hi_q;

	// extend and seed beats never report association
	a_no_assoc_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !is_query) |-> !assoc_q)
		else $error("association set on an extent update");

	// projected angle stays within plus or minus pi
	a_ang_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ($signed(result.projected_angle) <= AW'(lspa_pkg::ANG_PI)
		&& $signed(result.projected_angle) >= -AW'(lspa_pkg::ANG_PI)))
		else $error("projected angle out of range");

	// a unit only finishes work that the sequencer issued
	a_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(crsp.done || mrsp.done || drsp.done) |-> pend_q)
		else $error("unit finished with nothing pending");

	// only one shared unit is started at a time
	a_one_start: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cr.start, mr.start, dr.start}))
		else $error("two units started together");
endmodule
`default_nettype wire
